// File: src/tbo_pkg.sv
package tbo_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxWidth = 3;

  typedef enum logic [RegIdxWidth-1:0] {
    RegMinX = 3'd0,
    RegMinY = 3'd1,
    RegMinZ = 3'd2,
    RegMaxX = 3'd3,
    RegMaxY = 3'd4,
    RegMaxZ = 3'd5
  } reg_idx_e;

endpackage

// File: src/tbo_axis.sv
module tbo_axis #(
  parameter int unsigned NW = 28,
  parameter int unsigned QW = 26,
  parameter int unsigned HW = 26
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] n_i [3],
  input  logic signed [QW-1:0] q_i [3][3],
  input  logic signed [HW-1:0] h_i [3],
  output logic                 sep_o
);

  // The axis component is split into a low half and a signed high half so that
  // every multiplier stays narrow; the halves are recombined in the rp_q and pp_q registers.
  localparam int unsigned LW = (NW + 1) / 2;
  localparam int unsigned UW = NW - LW;
  localparam int unsigned PW = NW + QW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned RLW = LW + 1 + HW;
  localparam int unsigned RUW = UW + HW;
  localparam int unsigned PLW = LW + 1 + QW;
  localparam int unsigned PUW = UW + QW;

  logic signed [NW-1:0] an [3];
  logic signed [LW:0] nl [3];
  logic signed [UW-1:0] nu [3];
  logic signed [LW:0] anl [3];
  logic signed [UW-1:0] anu [3];
  logic signed [RLW-1:0] rpl_q [3];
  logic signed [RUW-1:0] rpu_q [3];
  logic signed [PLW-1:0] ppl_q [3][3];
  logic signed [PUW-1:0] ppu_q [3][3];
  logic signed [PW-1:0] rp_q [3];
  logic signed [PW-1:0] pp_q [3][3];
  logic signed [SW-1:0] r_q;
  logic signed [SW-1:0] p_q [3];
  logic signed [SW-1:0] r_d;
  logic signed [SW-1:0] p_d [3];
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an[i] = n_i[i] < 0 ? -n_i[i] : n_i[i];
      nl[i] = {1'b0, n_i[i][LW-1:0]};
      nu[i] = n_i[i][NW-1:LW];
      anl[i] = {1'b0, an[i][LW-1:0]};
      anu[i] = an[i][NW-1:LW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rpl_q[i] <= RLW'(anl[i]) * RLW'(h_i[i]);
        rpu_q[i] <= RUW'(anu[i]) * RUW'(h_i[i]);
        for (int k = 0; k < 3; k++) begin
          ppl_q[k][i] <= PLW'(nl[i]) * PLW'(q_i[k][i]);
          ppu_q[k][i] <= PUW'(nu[i]) * PUW'(q_i[k][i]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        rp_q[i] <= (PW'(rpu_q[i]) <<< LW) + PW'(rpl_q[i]);
        for (int k = 0; k < 3; k++) begin
          pp_q[k][i] <= (PW'(ppu_q[k][i]) <<< LW) + PW'(ppl_q[k][i]);
        end
      end
      r_q <= r_d;
      p_q <= p_d;
    end
  end

  always_comb begin
    r_d = SW'(rp_q[0]) + SW'(rp_q[1]) + SW'(rp_q[2]);
    for (int k = 0; k < 3; k++) begin
      p_d[k] = SW'(pp_q[k][0]) + SW'(pp_q[k][1]) + SW'(pp_q[k][2]);
    end
    lo = p_q[0];
    hi = p_q[0];
    for (int k = 1; k < 3; k++) begin
      if (p_q[k] < lo) lo = p_q[k];
      if (p_q[k] > hi) hi = p_q[k];
    end
    sep_o = (r_q < lo) || (hi < -r_q);
  end

endmodule

// File: src/triangle_box_overlap.sv
// Separating-axis overlap test of one triangle against an axis-aligned box
// set by the six corner registers. One beat per cycle is accepted while the
// output is not stalled, and a stall on the output holds the whole pipeline.
// Touching counts as overlap.
module triangle_box_overlap
  import tbo_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RegIdxWidth-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]   cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // overlaps
  output logic [7:0]               m_axis_tdata
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned QW = CW + 2;
  localparam int unsigned EW = CW + 3;
  localparam int unsigned NW = 2 * EW + 1;
  localparam int unsigned FW = EW + 1;
  localparam int unsigned Lat = 6;
  localparam logic unused_frac = (FRAC_BITS > 0);

  logic signed [CW-1:0] reg_q [NumRegs];
  logic signed [QW-1:0] q_q [3][3];
  logic signed [QW-1:0] h_q [3];
  logic signed [QW-1:0] q2_q [3][3];
  logic signed [QW-1:0] h2_q [3];
  logic signed [EW-1:0] e_q [3][3];
  logic signed [NW-1:0] nrm_q [3];
  logic [Lat-1:0] vld_q;
  logic en;
  logic [12:0] sep;
  logic signed [FW-1:0] ax_n [12][3];
  logic signed [NW-1:0] axn_w [12][3];

  assign en = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata = {7'd0, ~(|sep)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) reg_q[i] <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i < RegIdxWidth'(NumRegs)) begin
        reg_q[cfg_idx_i] <= cfg_data_i;
      end
      if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        h_q[i] <= QW'(reg_q[3+i]) - QW'(reg_q[i]);
        for (int k = 0; k < 3; k++) begin
          q_q[k][i] <= (QW'($signed(s_axis_tdata[(3*k+i)*CW +: CW])) <<< 1)
                       - QW'(reg_q[i]) - QW'(reg_q[3+i]);
        end
      end
      q2_q <= q_q;
      h2_q <= h_q;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          e_q[k][i] <= EW'(q_q[(k+1)%3][i]) - EW'(q_q[k][i]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= NW'(e_q[0][(i+1)%3]) * NW'(e_q[1][(i+2)%3])
                  - NW'(e_q[0][(i+2)%3]) * NW'(e_q[1][(i+1)%3]);
      end
    end
  end

  always_comb begin
    for (int u = 0; u < 3; u++) begin
      for (int k = 0; k < 3; k++) begin
        ax_n[3*u+k][u] = '0;
        ax_n[3*u+k][(u+1)%3] = -FW'(e_q[k][(u+2)%3]);
        ax_n[3*u+k][(u+2)%3] = FW'(e_q[k][(u+1)%3]);
      end
      for (int i = 0; i < 3; i++) ax_n[9+u][i] = (i == u) ? FW'(1) : '0;
    end
    for (int a = 0; a < 12; a++)
      for (int i = 0; i < 3; i++) axn_w[a][i] = NW'(ax_n[a][i]);
  end

  for (genvar a = 0; a < 12; a++) begin : g_ax
    logic signed [NW-1:0] n_d [3];
    logic s0_q, s1_q;
    assign n_d = axn_w[a];
    tbo_axis #(.NW(NW), .QW(QW), .HW(QW)) u_ax (
      .clk_i, .en_i(en), .n_i(n_d), .q_i(q2_q), .h_i(h2_q), .sep_o(s0_q)
    );
    always_ff @(posedge clk_i) if (en) s1_q <= s0_q;
    assign sep[a] = s1_q | unused_frac & 1'b0;
  end

  logic signed [QW-1:0] q3_q [3][3];
  logic signed [QW-1:0] h3_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      q3_q <= q2_q;
      h3_q <= h2_q;
    end
  end

  tbo_axis #(.NW(NW), .QW(QW), .HW(QW)) u_nrm (
    .clk_i, .en_i(en), .n_i(nrm_q), .q_i(q3_q), .h_i(h3_q), .sep_o(sep[12])
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("beat lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Lat-1] |-> s_axis_tready) else $error("stalled while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[0] == $past(s_axis_tvalid)) else $error("valid lost");

endmodule
